// ===== hdl/rps_pkg.sv =====
// Package for the report packetizer: field widths, channel codes, default sizes
// and the control word that steers the byte cell chain. No dependencies.
package rps_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;

    localparam int FRAMED_PAYLOAD_DEF = 61;
    localparam int PLAIN_PAYLOAD_DEF  = 62;
    localparam int REPORT_BYTES_DEF   = 64;

    localparam logic CH_FRAMED = 1'b0;
    localparam logic CH_PLAIN  = 1'b1;

    typedef struct packed {
        logic load;   // write the input byte into the addressed cell
        logic shift;  // move every byte one cell toward the head
    } t_cell_ctl;

endpackage

// ===== hdl/rps_cell.sv =====
// One byte cell of the payload chain: loads a new byte or takes its neighbor's.
// Depends on rps_pkg.
module rps_cell
    import rps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_load_byte,
    input  logic [BYTE_W-1:0] i_nbr_byte,
    output logic [BYTE_W-1:0] o_byte
);

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_load_byte;
        end else if (i_shift) begin
            r_byte <= i_nbr_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== hdl/rps_chain.sv =====
// Row of byte cells holding the buffered payload; the head cell feeds the output.
// Depends on rps_pkg and rps_cell.
module rps_chain
    import rps_pkg::*;
#(
    parameter int DEPTH = PLAIN_PAYLOAD_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [IW-1:0]     i_idx,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_head
);

    logic [BYTE_W-1:0] w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [BYTE_W-1:0] w_nbr;
        if (g == DEPTH - 1) begin : g_tail
            assign w_nbr = w_cell[g];
        end else begin : g_mid
            assign w_nbr = w_cell[g+1];
        end
        rps_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (i_ctl.load && (i_idx == IW'(g))),
            .i_shift     (i_ctl.shift),
            .i_load_byte (i_byte),
            .i_nbr_byte  (w_nbr),
            .o_byte      (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

// ===== hdl/report_packetizer_with_sum.sv =====
// Report packetizer with byte sum: top level with fill control, emitter and output stage.
// Depends on rps_pkg, rps_chain and rps_cell.
//
// A flushing byte starts the emitter, which loads each word into the output stage register.
// Throughput: one input word per cycle while filling; a flush then emits REPORT_BYTES
// words (framed) or the held count (plain), one per cycle unless the output stalls,
// driven by the position counter that walks the cell chain; input is held off meanwhile.
// Reset (synchronous, active low) clears link_up, the fill count, the sum, the emitter
// state and the output valid flag; the payload cells and output data are not cleared.
module report_packetizer_with_sum
    import rps_pkg::*;
#(
    parameter int FRAMED_PAYLOAD = FRAMED_PAYLOAD_DEF,
    parameter int PLAIN_PAYLOAD  = PLAIN_PAYLOAD_DEF,
    parameter int REPORT_BYTES   = REPORT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: link_up
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] channel
    input  logic              s_tlast,   // end_of_message
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast    // end_of_packet
);

    // One shared store serves both channels, so it is as deep as the larger payload.
    localparam int STORE_DEPTH = (PLAIN_PAYLOAD > FRAMED_PAYLOAD) ? PLAIN_PAYLOAD
                                                                   : FRAMED_PAYLOAD;
    localparam int IW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    // Position counter must reach REPORT_BYTES-1 and compare against count+2.
    localparam int SPAN = (REPORT_BYTES > STORE_DEPTH + 3) ? REPORT_BYTES : STORE_DEPTH + 3;
    localparam int PW   = $clog2(SPAN);

    localparam logic [CW-1:0] FRAMED_CAP = CW'(FRAMED_PAYLOAD);
    localparam logic [CW-1:0] PLAIN_CAP  = CW'(PLAIN_PAYLOAD);
    localparam logic [PW-1:0] LAST_POS   = PW'(REPORT_BYTES - 1);

    logic              r_link;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_emit, n_emit;
    logic              r_chan, n_chan;
    logic [PW-1:0]     r_pos, n_pos;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_olast, n_olast;

    logic              w_accept;
    logic              w_store;
    logic [CW-1:0]     w_cap;
    logic [CW-1:0]     w_base;
    logic [CW-1:0]     w_cnt_inc;
    logic [SUM_W-1:0]  w_sum_base;
    logic              w_flush;
    logic              w_adv;
    logic [PW-1:0]     w_n_ext;
    logic [BYTE_W-1:0] w_head;
    logic              w_last;
    t_cell_ctl         w_ctl;

    // Hold off input while emitting; a byte may still enter while the last word waits.
    assign s_tready = !r_emit;
    assign w_accept = s_tvalid && s_tready;
    assign w_store  = w_accept && r_link;

    // Discard held bytes if the buffer is already full for this byte's channel.
    assign w_cap      = (s_tuser == CH_PLAIN) ? PLAIN_CAP : FRAMED_CAP;
    assign w_base     = (r_cnt >= w_cap) ? '0 : r_cnt;
    assign w_sum_base = (r_cnt >= w_cap) ? '0 : r_sum;
    assign w_cnt_inc  = w_base + CW'(1);
    assign w_flush    = (w_cnt_inc == w_cap) || s_tlast;

    // Advance the emitter when the output stage is free or being drained.
    assign w_adv   = r_emit && (!r_ovalid || m_tready);
    assign w_n_ext = PW'(r_cnt);

    always_comb begin
        w_ctl.load  = w_store;
        w_ctl.shift = 1'b0;
        n_obyte     = r_obyte;
        n_olast     = r_olast;
        w_last      = 1'b0;
        if (r_chan == CH_PLAIN) begin
            n_obyte     = w_head;
            w_ctl.shift = w_adv;
            w_last      = (r_pos == w_n_ext - PW'(1));
        end else begin
            w_last = (r_pos == LAST_POS);
            if (r_pos == '0) begin
                n_obyte = BYTE_W'(r_cnt);
            end else if (r_pos <= w_n_ext) begin
                n_obyte     = w_head;
                w_ctl.shift = w_adv;
            end else if (r_pos == w_n_ext + PW'(1)) begin
                n_obyte = r_sum[SUM_W-1 -: BYTE_W];
            end else if (r_pos == w_n_ext + PW'(2)) begin
                n_obyte = r_sum[BYTE_W-1:0];
            end else begin
                n_obyte = '0;
            end
        end
        if (!w_adv) begin
            n_obyte = r_obyte;
        end else begin
            n_olast = w_last;
        end
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_emit   = r_emit;
        n_chan   = r_chan;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        if (m_tready) begin
            n_ovalid = 1'b0;
        end
        if (w_store) begin
            // Store the byte, then hand the packet to the emitter if it closes one.
            n_cnt = w_cnt_inc;
            n_sum = w_sum_base + SUM_W'(s_tdata);
            if (w_flush) begin
                n_emit = 1'b1;
                n_chan = s_tuser;
                n_pos  = '0;
            end
        end
        if (w_adv) begin
            n_ovalid = 1'b1;
            n_pos    = r_pos + PW'(1);
            if (w_last) begin
                n_emit = 1'b0;
                n_cnt  = '0;
                n_sum  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link   <= 1'b0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_emit   <= 1'b0;
            r_chan   <= CH_FRAMED;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_link <= i_cfg_wdata;
            end
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_emit   <= n_emit;
            r_chan   <= n_chan;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    rps_chain #(
        .DEPTH (STORE_DEPTH),
        .IW    (IW)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_idx  (w_base[IW-1:0]),
        .i_byte (s_tdata),
        .o_head (w_head)
    );

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_obyte;
    assign m_tlast  = r_olast;

    // Fill count never runs past the store.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    // A byte that closes a packet starts the emitter.
    a_flush_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_store && w_flush) |=> r_emit)
        else $error("flush did not start emission");

    // Plain emission never reads past the held count.
    a_plain_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit && r_chan == CH_PLAIN) |-> (r_pos < w_n_ext))
        else $error("plain emission past held bytes");

    // Finishing a packet leaves the buffer empty.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_emit) |-> (r_cnt == '0 && r_sum == '0))
        else $error("buffer not cleared after packet");

endmodule
